// ----- hw/rtl/mru_pkg.sv -----
// mru_pkg: shared types and constants for the MRU replacement cache.
// Beat payload structs, update opcodes and default sizes.
// No dependencies.
`default_nettype none

package mru_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int IN_KEY_W = 16;
  localparam int CAP_W    = 5;
  localparam int OCC_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [IN_KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_PROMOTE,
    UPD_REPLACE,
    UPD_FILL
  } upd_op_t;

  typedef struct packed {
    logic    en;
    upd_op_t op;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mru_lookup.sv -----
// mru_lookup: parallel key match, victim/free slot pick and result build.
// Purely combinational; uses mru_pkg.
`default_nettype none

module mru_lookup #(
  parameter int ENTRIES  = mru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mru_pkg::KEY_BITS_DEF
) (
  input  logic                              req_kind,
  input  logic [KEY_BITS-1:0]               req_key,
  input  logic [mru_pkg::CAP_W-1:0]         capacity,
  input  logic [KEY_BITS-1:0]               ent_key   [ENTRIES],
  input  logic [ENTRIES-1:0]                ent_valid,
  input  logic [$clog2(ENTRIES)-1:0]        ent_rank  [ENTRIES],
  input  logic [$clog2(ENTRIES+1)-1:0]      fill,
  output mru_pkg::upd_op_t                  op,
  output logic [ENTRIES-1:0]                sel,
  output logic [$clog2(ENTRIES)-1:0]        hit_rank,
  output mru_pkg::out_item_t                result
);

  localparam int RW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > mru_pkg::CAP_W) ? FW : mru_pkg::CAP_W;

  logic [ENTRIES-1:0]  match, zero_rank, free;
  logic [ENTRIES-1:0]  hit_sel, zr_sel, free_sel;
  logic [CW-1:0]       cap_w, cap_eff, fill_w;
  logic                evict_cond;
  logic [KEY_BITS-1:0] mru_key;
  logic [FW-1:0]       fill_nxt;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = ent_valid[i] && (ent_key[i] == req_key);
      zero_rank[i] = ent_valid[i] && (ent_rank[i] == '0);
      free[i]      = !ent_valid[i];
    end
  end

  // lowest set bit of each request vector
  assign hit_sel  = match & (~match + 1'b1);
  assign zr_sel   = zero_rank & (~zero_rank + 1'b1);
  assign free_sel = free & (~free + 1'b1);

  assign cap_w      = CW'(capacity);
  assign cap_eff    = (cap_w > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_w;
  assign fill_w     = CW'(fill);
  assign evict_cond = (fill_w >= cap_eff) && (fill != '0);

  always_comb begin
    hit_rank = '0;
    mru_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (ent_rank[i] & {RW{hit_sel[i]}});
      mru_key  = mru_key | (ent_key[i] & {KEY_BITS{zr_sel[i]}});
    end
  end

  always_comb begin
    op  = mru_pkg::UPD_NONE;
    sel = '0;
    if (cap_eff != '0) begin
      if (|match) begin
        op  = mru_pkg::UPD_PROMOTE;
        sel = hit_sel;
      end else if (req_kind == mru_pkg::KIND_INSERT) begin
        if (evict_cond) begin
          if (|zero_rank) begin
            op  = mru_pkg::UPD_REPLACE;
            sel = zr_sel;
          end
        end else if (|free) begin
          op  = mru_pkg::UPD_FILL;
          sel = free_sel;
        end
      end
    end
  end

  assign fill_nxt = fill + FW'(op == mru_pkg::UPD_FILL);

  always_comb begin
    result.hit         = (op == mru_pkg::UPD_PROMOTE);
    result.evicted     = (op == mru_pkg::UPD_REPLACE);
    result.evicted_key = result.evicted ? mru_pkg::IN_KEY_W'(mru_key) : '0;
    result.occupancy   = mru_pkg::OCC_W'(fill_nxt);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mru_store.sv -----
// mru_store: entry keys, valid bits, recency ranks and fill count.
// Applies one update per cycle; uses mru_pkg.
`default_nettype none

module mru_store #(
  parameter int ENTRIES  = mru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mru_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mru_pkg::upd_ctl_t            ctl,
  input  logic [ENTRIES-1:0]           sel,
  input  logic [$clog2(ENTRIES)-1:0]   hit_rank,
  input  logic [KEY_BITS-1:0]          req_key,
  output logic [KEY_BITS-1:0]          ent_key   [ENTRIES],
  output logic [ENTRIES-1:0]           ent_valid,
  output logic [$clog2(ENTRIES)-1:0]   ent_rank  [ENTRIES],
  output logic [$clog2(ENTRIES+1)-1:0] fill
);

  localparam int RW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] key_r   [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [RW-1:0]       rank_r  [ENTRIES];
  logic [FW-1:0]       fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (ctl.en) begin
      unique case (ctl.op)
        mru_pkg::UPD_NONE: begin
        end
        mru_pkg::UPD_PROMOTE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
              rank_r[i] <= '0;
            end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
              rank_r[i] <= rank_r[i] + RW'(1);
            end
          end
        end
        mru_pkg::UPD_REPLACE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
              rank_r[i] <= '0;
            end
          end
        end
        mru_pkg::UPD_FILL: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
              valid_r[i] <= 1'b1;
              rank_r[i]  <= '0;
            end else if (valid_r[i]) begin
              rank_r[i] <= rank_r[i] + RW'(1);
            end
          end
          fill_r <= fill_r + FW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && (ctl.op == mru_pkg::UPD_REPLACE || ctl.op == mru_pkg::UPD_FILL)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          key_r[i] <= req_key;
        end
      end
    end
  end

  assign ent_key   = key_r;
  assign ent_valid = valid_r;
  assign ent_rank  = rank_r;
  assign fill      = fill_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mru_replacement_cache.sv -----
// mru_replacement_cache: fully associative key cache, MRU replacement.
// Top level; instantiates mru_lookup and mru_store, uses mru_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  input    | start & !busy              | in_item  (kind, key)
//  result   | out_strobe, one cycle      | out_item (hit, evicted, evicted_key, occupancy)
//  config   | cfg_we                     | cfg_wdata (capacity)
//
// One beat per cycle; start is registered into in_v_r with the input item, and the result into out_item_r.
// busy is always low: the state update of one beat is complete before the next
// beat reaches the lookup stage.
// Synchronous reset clears valid bits, ranks, fill count and capacity (to 16).
// The receiver cannot stall; out_strobe is high for exactly one cycle per beat.
`default_nettype none

module mru_replacement_cache #(
  parameter int ENTRIES  = mru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mru_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  mru_pkg::in_item_t         in_item,
  output logic                      out_strobe,
  output mru_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [mru_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int RW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);

  logic                      in_v_r;
  logic                      in_kind_r;
  logic [KEY_BITS-1:0]       in_key_r;
  logic [mru_pkg::CAP_W-1:0] cap_r;
  logic                      out_strobe_r;
  mru_pkg::out_item_t        out_item_r;

  logic [KEY_BITS-1:0] ent_key   [ENTRIES];
  logic [ENTRIES-1:0]  ent_valid;
  logic [RW-1:0]       ent_rank  [ENTRIES];
  logic [FW-1:0]       fill;
  logic [ENTRIES-1:0]  sel;
  logic [RW-1:0]       hit_rank;
  mru_pkg::upd_op_t    op;
  mru_pkg::upd_ctl_t   ctl;
  mru_pkg::out_item_t  result;
  logic [ENTRIES-1:0]  mru_mark;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      cap_r        <= mru_pkg::CAP_RESET;
    end else begin
      in_v_r       <= start && !busy;
      out_strobe_r <= in_v_r;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_kind_r <= in_item.kind;
      in_key_r  <= KEY_BITS'(in_item.key);
    end
    if (in_v_r) begin
      out_item_r <= result;
    end
  end

  mru_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .req_kind  (in_kind_r),
    .req_key   (in_key_r),
    .capacity  (cap_r),
    .ent_key   (ent_key),
    .ent_valid (ent_valid),
    .ent_rank  (ent_rank),
    .fill      (fill),
    .op        (op),
    .sel       (sel),
    .hit_rank  (hit_rank),
    .result    (result)
  );

  assign ctl.en = in_v_r;
  assign ctl.op = op;

  mru_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sel       (sel),
    .hit_rank  (hit_rank),
    .req_key   (in_key_r),
    .ent_key   (ent_key),
    .ent_valid (ent_valid),
    .ent_rank  (ent_rank),
    .fill      (fill)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      mru_mark[i] = ent_valid[i] && (ent_rank[i] == '0);
    end
  end

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 2))
    else $error("result strobe without a beat two cycles earlier");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ent_valid) == fill)
    else $error("fill count disagrees with valid bits");

  a_single_mru: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mru_mark) && ((fill == '0) || (mru_mark != '0)))
    else $error("most recent rank not held by exactly one valid entry");

  a_evict_needs_insert: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (op == mru_pkg::UPD_REPLACE) |-> (fill != '0) && !(|(sel & ~ent_valid)))
    else $error("eviction of an empty slot");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for mru_replacement_cache: directed and random lookup/insert beats
// checked against a cycle-free predictor of the MRU cache. Uses mru_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_LINES   = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  mru_pkg::in_item_t in_item = '0;
  logic out_strobe;
  mru_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [mru_pkg::CAP_W-1:0] cfg_wdata = '0;

  mru_replacement_cache dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted cache contents
  logic [mru_pkg::IN_KEY_W-1:0] line_key [NUM_LINES];
  bit line_valid [NUM_LINES];
  int unsigned line_rank [NUM_LINES];
  int unsigned line_fill;
  logic [mru_pkg::CAP_W-1:0] cap_setting;

  mru_pkg::in_item_t tx_beats [$];
  mru_pkg::out_item_t expected_results [$];

  int gap_pct = 36;
  int beats_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int mismatches = 0;
  int cap_writes = 0;
  int cycles = 0;

  function automatic mru_pkg::out_item_t cache_access(mru_pkg::in_item_t beat);
    mru_pkg::out_item_t r;
    int eff_cap;
    int slot;
    int tgt;
    int i;
    int unsigned old_rank;
    r = '0;
    eff_cap = (cap_setting > NUM_LINES) ? NUM_LINES : int'(cap_setting);
    slot = -1;
    tgt = -1;
    if (eff_cap != 0) begin
      for (i = 0; i < NUM_LINES; i++)
        if (slot < 0 && line_valid[i] && line_key[i] == beat.key) slot = i;
      if (slot >= 0) begin
        r.hit = 1'b1;
        old_rank = line_rank[slot];
        for (i = 0; i < NUM_LINES; i++)
          if (line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
        line_rank[slot] = 0;
      end else if (beat.kind == mru_pkg::KIND_INSERT) begin
        if (line_fill >= eff_cap && line_fill > 0) begin
          // full: the most recent line is replaced in place
          for (i = 0; i < NUM_LINES; i++)
            if (tgt < 0 && line_valid[i] && line_rank[i] == 0) tgt = i;
          if (tgt >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = line_key[tgt];
            line_key[tgt] = beat.key;
            line_rank[tgt] = 0;
          end
        end else begin
          for (i = 0; i < NUM_LINES; i++)
            if (tgt < 0 && !line_valid[i]) tgt = i;
          if (tgt >= 0) begin
            for (i = 0; i < NUM_LINES; i++)
              if (line_valid[i]) line_rank[i]++;
            line_valid[tgt] = 1'b1;
            line_key[tgt] = beat.key;
            line_rank[tgt] = 0;
            line_fill++;
          end
        end
      end
    end
    r.occupancy = line_fill[mru_pkg::OCC_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(cache_access(in_item));
        beats_sent++;
      end
      if (!start || !busy) begin
        if (tx_beats.size() > 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          in_item <= tx_beats[0];
          tx_beats.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    mru_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hit=%0b ev=%0b key=%h occ=%0d",
                   out_item.hit, out_item.evicted, out_item.evicted_key,
                   out_item.occupancy);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (out_item.hit) hits_seen++;
        if (out_item.evicted) evictions_seen++;
        if (out_item.hit !== want.hit || out_item.evicted !== want.evicted ||
            out_item.evicted_key !== want.evicted_key ||
            out_item.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch at result %0d: exp hit=%0b ev=%0b key=%h occ=%0d, ",
                   results_checked, want.hit, want.evicted, want.evicted_key,
                   want.occupancy);
            $display("got hit=%0b ev=%0b key=%h occ=%0d",
                     out_item.hit, out_item.evicted,
                     out_item.evicted_key, out_item.occupancy);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic kind, logic [mru_pkg::IN_KEY_W-1:0] key);
    mru_pkg::in_item_t b;
    b.kind = kind;
    b.key = key;
    tx_beats.push_back(b);
  endtask

  task automatic wait_idle();
    while (tx_beats.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [mru_pkg::CAP_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cap_setting = value;
    cap_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(logic [mru_pkg::CAP_W-1:0] cap, int count, int gap);
    logic [mru_pkg::IN_KEY_W-1:0] pool [20];
    logic kind;
    logic [mru_pkg::IN_KEY_W-1:0] key;
    int n;
    write_capacity(cap);
    gap_pct = gap;
    foreach (pool[k]) pool[k] = mru_pkg::IN_KEY_W'($urandom);
    for (n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < 60) ? mru_pkg::KIND_INSERT : mru_pkg::KIND_LOOKUP;
      key = ($urandom_range(99) < 85) ? pool[$urandom_range(19)]
                                      : mru_pkg::IN_KEY_W'($urandom);
      send(kind, key);
    end
  endtask

  initial begin
    int p;
    foreach (line_valid[i]) begin
      line_valid[i] = 1'b0;
      line_rank[i] = 0;
      line_key[i] = '0;
    end
    line_fill = 0;
    cap_setting = mru_pkg::CAP_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: empty-cache miss, key extremes, hit on both kinds
    send(mru_pkg::KIND_LOOKUP, 16'h0000);
    send(mru_pkg::KIND_INSERT, 16'h0000);
    send(mru_pkg::KIND_INSERT, 16'hFFFF);
    send(mru_pkg::KIND_LOOKUP, 16'hFFFF);
    send(mru_pkg::KIND_INSERT, 16'h0000);
    send(mru_pkg::KIND_LOOKUP, 16'h1234);
    send(mru_pkg::KIND_LOOKUP, 16'h0000);
    // capacity lowered below and then to fill: eviction keeps occupancy at or above capacity
    write_capacity(5'd1);
    send(mru_pkg::KIND_INSERT, 16'h5555);
    write_capacity(5'd2);
    send(mru_pkg::KIND_INSERT, 16'hAAAA);
    send(mru_pkg::KIND_LOOKUP, 16'hFFFF);
    // capacity zero: all misses, nothing stored
    write_capacity(5'd0);
    send(mru_pkg::KIND_LOOKUP, 16'hFFFF);
    send(mru_pkg::KIND_INSERT, 16'h1111);
    // capacity above the line count
    write_capacity(5'd31);
    send(mru_pkg::KIND_INSERT, 16'h1111);
    send(mru_pkg::KIND_INSERT, 16'h8001);
    send(mru_pkg::KIND_LOOKUP, 16'h1111);

    random_phase(5'd3, 65, 36);
    random_phase(5'd1, 60, 36);
    random_phase(5'd6, 65, 36);
    random_phase(5'd0, 50, 36);
    random_phase(5'd9, 70, 36);
    random_phase(5'd12, 70, 0);
    random_phase(5'd16, 90, 36);
    random_phase(5'd31, 70, 36);
    random_phase(5'd2, 60, 36);
    random_phase(5'd16, 80, 36);
    random_phase(5'd24, 60, 36);
    random_phase(5'd0, 40, 36);
    for (p = 0; p < 4; p++)
      random_phase(mru_pkg::CAP_W'($urandom_range(31)), 55, 36);

    wait_idle();
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("%0d beats over %0d capacity settings, %0d results checked",
             beats_sent, cap_writes + 1, results_checked);
    $display("%0d hits, %0d evictions, %0d mismatches",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mru_pkg.sv
hw/rtl/mru_lookup.sv
hw/rtl/mru_store.sv
hw/rtl/mru_replacement_cache.sv
sim/testbench.sv
